/* rtl/core/slel_pkg.sv */
package slel_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = 5;
   localparam int VALUE_W  = 32;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_SEARCH = 2'd2;

   typedef struct packed {
      logic                      do_ins;
      logic                      do_rem;
      logic signed [VALUE_W-1:0] key;
   } slel_ctl_type;

endpackage

/* rtl/core/slel_cell.sv */
module slel_cell
   import slel_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  slel_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] left_val,
   input  logic                      left_valid,
   input  logic                      left_less,
   input  logic signed [VALUE_W-1:0] right_val,
   input  logic                      right_valid,
   output logic signed [VALUE_W-1:0] val,
   output logic                      valid,
   output logic                      less,
   output logic                      hit
);

   logic signed [VALUE_W-1:0] val_ff;
   logic signed [VALUE_W-1:0] val_in;
   logic                      valid_ff;
   logic                      valid_in;

   always_comb begin
      less = valid_ff && (val_ff < ctl.key);
      hit  = valid_ff && !less && left_less && (val_ff == ctl.key);
   end

   always_comb begin
      val_in   = val_ff;
      valid_in = valid_ff;
      if (ctl.do_ins && !less) begin
         if (left_less) begin
            val_in   = ctl.key;
            valid_in = 1'b1;
         end else begin
            val_in   = left_val;
            valid_in = left_valid;
         end
      end else if (ctl.do_rem && !less) begin
         val_in   = right_val;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val   = val_ff;
   assign valid = valid_ff;

endmodule

/* rtl/core/sorted_list_engine_core.sv */
// Sorted list engine: keeps up to CAPACITY signed 32-bit values in ascending
// order, duplicates allowed, in a row of cells that each hold one entry.
// A request transaction is taken at a rising edge where start is high and busy
// is low; req_action selects insert, remove or search and req_value is the key.
// Every request gives exactly one response transaction: rsp_strobe is high for
// one cycle with rsp_ok, rsp_count and rsp_empty_res.
// Latency: the request is registered at the accepting edge, every cell compares
// the key against its entry and shifts towards or away from its neighbour on
// the next edge, and the response is shown in the cycle after that edge.
// Throughput is one transaction per cycle, since one compare-and-shift step of
// the cell row finishes each operation and the next request sees the result.
// Reset empties the list and holds busy high for one cycle afterwards.
// The receiver cannot stall; a response is present for one cycle only.
module sorted_list_engine_core
   import slel_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_strobe,
   output logic                      rsp_ok,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic                      rsp_empty_res
);

   logic                      busy_ff;
   logic                      vld_ff;
   logic [1:0]                act_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic [COUNT_W-1:0]        count_in;
   logic                      strobe_ff;
   logic                      ok_ff;
   logic                      ok_in;
   logic                      accept;
   logic                      full;
   logic                      found;
   slel_ctl_type              ctl;

   logic signed [VALUE_W-1:0] cell_val   [CAPACITY];
   logic [CAPACITY-1:0]       cell_valid;
   logic [CAPACITY-1:0]       cell_less;
   logic [CAPACITY-1:0]       cell_hit;

   assign accept = start && !busy_ff;
   assign full   = cell_valid[CAPACITY-1];
   assign found  = |cell_hit;

   always_comb begin
      ctl.key    = key_ff;
      ctl.do_ins = vld_ff && (act_ff == ACT_INSERT) && !full;
      ctl.do_rem = vld_ff && (act_ff == ACT_REMOVE) && found;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] lv;
      logic                      lvd;
      logic                      lls;
      logic signed [VALUE_W-1:0] rv;
      logic                      rvd;

      if (i == 0) begin : g_first
         assign lv  = key_ff;
         assign lvd = 1'b0;
         assign lls = 1'b1;
      end else begin : g_mid_l
         assign lv  = cell_val[i-1];
         assign lvd = cell_valid[i-1];
         assign lls = cell_less[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rv  = key_ff;
         assign rvd = 1'b0;
      end else begin : g_mid_r
         assign rv  = cell_val[i+1];
         assign rvd = cell_valid[i+1];
      end

      slel_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_val    (lv),
         .left_valid  (lvd),
         .left_less   (lls),
         .right_val   (rv),
         .right_valid (rvd),
         .val         (cell_val[i]),
         .valid       (cell_valid[i]),
         .less        (cell_less[i]),
         .hit         (cell_hit[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      ok_in    = 1'b0;
      case (act_ff)
         ACT_INSERT: begin
            ok_in = !full;
            if (!full) begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ACT_REMOVE: begin
            ok_in = found;
            if (found) begin
               count_in = count_ff - COUNT_W'(1);
            end
         end
         ACT_SEARCH: begin
            ok_in = found;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         vld_ff    <= 1'b0;
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         busy_ff   <= 1'b0;
         vld_ff    <= accept;
         strobe_ff <= vld_ff;
         if (vld_ff) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         key_ff <= req_value;
      end
      if (vld_ff) begin
         ok_ff <= ok_in;
      end
   end

   assign busy          = busy_ff;
   assign rsp_strobe    = strobe_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_count     = count_ff;
   assign rsp_empty_res = (count_ff == '0);

   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      COUNT_W'($countones(cell_valid)) == count_ff)
      else $error("Entry count disagrees with the cell valid bits.");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_hit))
      else $error("More than one cell claims the first match.");

   a_response_follows_request: assert property (@(posedge clock) disable iff (reset)
      vld_ff |=> rsp_strobe)
      else $error("A registered request did not give a response transaction.");

   a_full_insert_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (vld_ff && (act_ff == ACT_INSERT) && full) |=> (!rsp_ok && $stable(count_ff)))
      else $error("Insert into a full list changed the contents.");

endmodule
